>>> rtl/ppgs_pkg.sv
// Shared constants, types and helper functions of the PPG heart rate and SpO2 estimator.
`timescale 1ns / 1ps

package ppgs_pkg;

  // Fixed-point format and history depths.
  localparam int unsigned FRAC_BITS      = 8;
  localparam int unsigned INTERVAL_DEPTH = 4;
  localparam int unsigned SPO2_DEPTH     = 8;

  localparam int unsigned IPTR_W  = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
  localparam int unsigned IFILL_W = $clog2(INTERVAL_DEPTH + 1);
  localparam int unsigned SPTR_W  = (SPO2_DEPTH > 1) ? $clog2(SPO2_DEPTH) : 1;
  localparam int unsigned SFILL_W = $clog2(SPO2_DEPTH + 1);
  localparam int unsigned STEP_W  = (IFILL_W > SFILL_W) ? IFILL_W : SFILL_W;

  // Field widths.
  localparam int unsigned SAMPLE_W   = 18;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned IVL_W      = 11;
  localparam int unsigned BPM_W      = 11;
  localparam int unsigned SPO2_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned ISUM_W     = IVL_W + IFILL_W;
  localparam int unsigned SSUM_W     = SPO2_W + SFILL_W;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] FINGER_THR_RST = 18'd50000;
  localparam logic [15:0]         MIN_IVL_RST    = 16'd300;
  localparam logic [15:0]         MAX_IVL_RST    = 16'd2000;
  localparam logic [15:0]         TIMEOUT_RST    = 16'd3000;
  localparam logic [15:0]         FLOOR_RST      = 16'd100;

  // Filter coefficients in Q16.
  localparam logic [31:0] K_DC     = 32'd328;
  localparam logic [31:0] K_AC     = 32'd6554;
  localparam logic [31:0] K_BAND   = 32'd16384;
  localparam logic [31:0] K_ENV    = 32'd64553;
  localparam logic [31:0] K_THR    = 32'd19661;
  localparam logic [31:0] K_SMOOTH = 32'd19661;

  // Rate and SpO2 constants.
  localparam logic [31:0] K_BPM_NUM       = 32'd9600000;  // 600000 tenths * 16
  localparam logic [15:0] BPM_CAP         = 16'd32752;    // 2047 in Q4
  localparam logic [10:0] IVL_CAP         = 11'd2047;
  localparam logic [12:0] BPM_OUT_CAP     = 13'd2047;
  localparam logic [15:0] MIN_AC_SAMPLES  = 16'd10;
  localparam logic [31:0] MIN_RMS_Q4      = 32'd160;
  localparam logic signed [31:0] DC_MIN_Q = 32'(10000) << FRAC_BITS;
  localparam logic [63:0] R_LOW_CLAMP     = 64'd73247;    // 170*R in Q16 reaches 190 tenths here
  localparam logic [31:0] K_SPO2_SLOPE    = 32'd170;
  localparam logic [63:0] SPO2_BASE_Q     = 64'd1040 << 16;
  localparam logic [9:0]  SPO2_LOW        = 10'd850;
  localparam logic [63:0] SPO2_HIGH       = 64'd1000;

  // Iteration counts of the shared divide and square-root unit.
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned ICNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FINGER_THR = 3'd0,
    CFG_MIN_IVL    = 3'd1,
    CFG_MAX_IVL    = 3'd2,
    CFG_TIMEOUT    = 3'd3,
    CFG_PEAK_FLOOR = 3'd4
  } ppgs_cfg_idx_e;

  typedef enum logic {
    ITER_DIV,
    ITER_SQRT
  } ppgs_iter_op_e;

  typedef struct packed {
    logic          start;
    ppgs_iter_op_e op;
    logic [63:0]   num;
    logic [63:0]   den;
  } ppgs_iter_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } ppgs_iter_rsp_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        neg;
  } ppgs_mul_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MUL,
    S_DC_IR, S_DC_RED, S_AC_IR, S_AC_RED, S_SQ_IR, S_SQ_RED,
    S_BAND, S_ENV, S_THR,
    S_BPM_SUM, S_BPM_NUM, S_BPM_DIV, S_BPM_SMOOTH, S_BPM_APPLY,
    S_SP_START, S_SP_D1, S_SP_S1, S_SP_D2, S_SP_S2, S_SP_NUM, S_SP_DEN,
    S_SP_R, S_SP_VAL, S_SP_WRITE, S_SP_SUM, S_SP_AVG,
    S_FIN
  } ppgs_state_e;

  // Magnitude of a signed 32-bit value.
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Operands for a rounded Q16 scaling of v by k.
  function automatic ppgs_mul_t scale_op(input logic signed [31:0] v, input logic [31:0] k);
    ppgs_mul_t m;
    m.a   = abs32(v);
    m.b   = k;
    m.neg = v[31];
    return m;
  endfunction

  // Operands for squaring an AC level reduced to Q4.
  function automatic ppgs_mul_t square_op(input logic signed [31:0] v);
    ppgs_mul_t m;
    m.a   = abs32(v) >> (FRAC_BITS - 4);
    m.b   = abs32(v) >> (FRAC_BITS - 4);
    m.neg = 1'b0;
    return m;
  endfunction

  // Unsigned 64-bit add that sticks at all ones.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

>>> rtl/ppgs_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps

interface ppgs_in_if;
  import ppgs_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] ir_sample;
  logic [SAMPLE_W-1:0] red_sample;
  logic [TIME_W-1:0]   time_ms;
  modport source (output valid, ir_sample, red_sample, time_ms, input ready);
  modport sink (input valid, ir_sample, red_sample, time_ms, output ready);
endinterface

interface ppgs_out_if;
  import ppgs_pkg::*;
  logic              valid;
  logic              ready;
  logic              finger_present;
  logic              beat_detected;
  logic [BPM_W-1:0]  bpm_tenths;
  logic [SPO2_W-1:0] spo2_tenths;
  modport source (output valid, finger_present, beat_detected, bpm_tenths, spo2_tenths,
                  input ready);
  modport sink (input valid, finger_present, beat_detected, bpm_tenths, spo2_tenths,
                output ready);
endinterface

interface ppgs_cfg_if;
  import ppgs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ppg_heart_rate_spo2_top.sv
// Top level of the PPG heart rate and SpO2 estimator with its sequencer and shared multiplier.
`timescale 1ns / 1ps

// A no-finger sample goes straight to the result; a finger sample first runs the filter,
// envelope and peak steps on the shared multiplier. A stored interval adds the rate and SpO2
// updates. These run up to five 64-step divides and two 32-step roots on the shared unit.
// One sample is in work at a time. The next is taken the cycle after the result enters the
// output register, and a result still held there stalls the sequencer. Reset is asynchronous
// and active low; it clears the control and estimator state and loads register defaults.
module ppg_heart_rate_spo2_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppgs_in_if.sink    sample_i,
  ppgs_out_if.source result_o,
  ppgs_cfg_if.sink   cfg_i
);
  import ppgs_pkg::*;

  ppgs_state_e state_q, state_d, ret_q, ret_d;

  // Configuration registers.
  logic [SAMPLE_W-1:0] fthr_q, fthr_d;
  logic [15:0] min_ivl_q, min_ivl_d, max_ivl_q, max_ivl_d;
  logic [15:0] tmo_q, tmo_d, pfloor_q, pfloor_d;

  // Latched sample.
  logic [SAMPLE_W-1:0] ir_q, ir_d, red_q, red_d;
  logic [TIME_W-1:0]   now_q, now_d;

  // Shared multiplier.
  ppgs_mul_t   mul_q, mul_d;
  logic [63:0] prod_q;
  logic [31:0] sc_mag;
  logic signed [31:0] sc;

  // Filter state.
  logic signed [31:0] ir_dc_q, ir_dc_d, red_dc_q, red_dc_d;
  logic signed [31:0] ir_ac_q, ir_ac_d, red_ac_q, red_ac_d;
  logic signed [31:0] band_q, band_d, env_q, env_d, prev_q, prev_d;
  logic               rising_q, rising_d;
  logic [TIME_W-1:0]  last_beat_q, last_beat_d;

  // Interval history and rate.
  logic [IVL_W-1:0]   iring_q [INTERVAL_DEPTH];
  logic [IVL_W-1:0]   iring_d [INTERVAL_DEPTH];
  logic [IPTR_W-1:0]  iwp_q, iwp_d, irp_q, irp_d;
  logic [IFILL_W-1:0] ifill_q, ifill_d, ifill_nx;
  logic [ISUM_W-1:0]  isum_q, isum_d;
  logic [15:0]        bpm_q, bpm_d, bpm_sm_q, bpm_sm_d;

  // AC accumulators and SpO2 history.
  logic [63:0]        ir_sq_q, ir_sq_d, red_sq_q, red_sq_d;
  logic [15:0]        acnt_q, acnt_d;
  logic [SPO2_W-1:0]  sring_q [SPO2_DEPTH];
  logic [SPO2_W-1:0]  sring_d [SPO2_DEPTH];
  logic [SPTR_W-1:0]  swp_q, swp_d, srp_q, srp_d;
  logic [SFILL_W-1:0] sfill_q, sfill_d, sfill_nx;
  logic [SSUM_W-1:0]  ssum_q, ssum_d, ssum_nx;
  logic [SPO2_W-1:0]  spavg_q, spavg_d, sval_q, sval_d;
  logic [31:0]        ir_rms_q, ir_rms_d, red_rms_q, red_rms_d;
  logic [63:0]        num_q, num_d;

  // Per-sample working values.
  logic               finger_q, finger_d, beat_q, beat_d;
  logic [TIME_W-1:0]  ivl_q, ivl_d;
  logic [STEP_W-1:0]  step_q, step_d;

  // Result register.
  logic               ov_q, ov_d, o_fing_q, o_fing_d, o_beat_q, o_beat_d;
  logic [BPM_W-1:0]   o_bpm_q, o_bpm_d;
  logic [SPO2_W-1:0]  o_spo2_q, o_spo2_d;

  ppgs_iter_req_t iter_req;
  ppgs_iter_rsp_t iter_rsp;

  logic signed [31:0] irx, redx, ir_raw, red_raw, mag, env_new, thr, floor_q;
  logic               rising, peak, tmo_hit;
  logic [63:0]        spv, spr;
  logic [15:0]        sm_eff;
  logic [16:0]        bpm_rnd;
  logic [12:0]        bpm_int;

  ppgs_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rsp_o  (iter_rsp)
  );

  // Scaled samples, raw AC terms and the rounded multiplier result.
  assign irx     = $signed(32'(ir_q) << FRAC_BITS);
  assign redx    = $signed(32'(red_q) << FRAC_BITS);
  assign ir_raw  = irx - ir_dc_q;
  assign red_raw = redx - red_dc_q;
  assign sc_mag  = 32'((prod_q + 64'd32768) >> 16);
  assign sc      = mul_q.neg ? -$signed(sc_mag) : $signed(sc_mag);
  assign floor_q = $signed(32'(pfloor_q) << FRAC_BITS);

  // Handshake outputs.
  assign sample_i.ready         = (state_q == S_IDLE);
  assign cfg_i.ready            = 1'b1;
  assign result_o.valid         = ov_q;
  assign result_o.finger_present = o_fing_q;
  assign result_o.beat_detected = o_beat_q;
  assign result_o.bpm_tenths    = o_bpm_q;
  assign result_o.spo2_tenths   = o_spo2_q;

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fthr_d      = fthr_q;
    min_ivl_d   = min_ivl_q;
    max_ivl_d   = max_ivl_q;
    tmo_d       = tmo_q;
    pfloor_d    = pfloor_q;
    ir_d        = ir_q;
    red_d       = red_q;
    now_d       = now_q;
    mul_d       = mul_q;
    ir_dc_d     = ir_dc_q;
    red_dc_d    = red_dc_q;
    ir_ac_d     = ir_ac_q;
    red_ac_d    = red_ac_q;
    band_d      = band_q;
    env_d       = env_q;
    prev_d      = prev_q;
    rising_d    = rising_q;
    last_beat_d = last_beat_q;
    iring_d     = iring_q;
    iwp_d       = iwp_q;
    irp_d       = irp_q;
    ifill_d     = ifill_q;
    isum_d      = isum_q;
    bpm_d       = bpm_q;
    bpm_sm_d    = bpm_sm_q;
    ir_sq_d     = ir_sq_q;
    red_sq_d    = red_sq_q;
    acnt_d      = acnt_q;
    sring_d     = sring_q;
    swp_d       = swp_q;
    srp_d       = srp_q;
    sfill_d     = sfill_q;
    ssum_d      = ssum_q;
    spavg_d     = spavg_q;
    sval_d      = sval_q;
    ir_rms_d    = ir_rms_q;
    red_rms_d   = red_rms_q;
    num_d       = num_q;
    finger_d    = finger_q;
    beat_d      = beat_q;
    ivl_d       = ivl_q;
    step_d      = step_q;
    ov_d        = ov_q;
    o_fing_d    = o_fing_q;
    o_beat_d    = o_beat_q;
    o_bpm_d     = o_bpm_q;
    o_spo2_d    = o_spo2_q;
    iter_req    = '0;

    mag      = $signed(abs32(band_q));
    env_new  = (mag > sc) ? mag : sc;
    thr      = (sc < floor_q) ? floor_q : sc;
    rising   = band_q > prev_q;
    peak     = rising_q && !rising && (band_q > thr);
    ifill_nx = (ifill_q == IFILL_W'(INTERVAL_DEPTH)) ? ifill_q : ifill_q + 1'b1;
    sfill_nx = (sfill_q == SFILL_W'(SPO2_DEPTH)) ? sfill_q : sfill_q + 1'b1;
    ssum_nx  = ssum_q + SSUM_W'(sring_q[srp_q]);
    spv      = SPO2_BASE_Q - prod_q;
    spr      = (spv + 64'd32768) >> 16;
    tmo_hit  = finger_q && (ivl_q > 32'(tmo_q));
    sm_eff   = tmo_hit ? 16'd0 : bpm_sm_q;
    bpm_rnd  = 17'(sm_eff) + 17'd8;
    bpm_int  = bpm_rnd[16:4];

    // Register writes.
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FINGER_THR: fthr_d    = cfg_i.data;
        CFG_MIN_IVL:    min_ivl_d = cfg_i.data[15:0];
        CFG_MAX_IVL:    max_ivl_d = cfg_i.data[15:0];
        CFG_TIMEOUT:    tmo_d     = cfg_i.data[15:0];
        CFG_PEAK_FLOOR: pfloor_d  = cfg_i.data[15:0];
        default: ;
      endcase
    end

    // The result beat leaves the output register.
    if (ov_q && result_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (sample_i.valid) begin
          ir_d    = sample_i.ir_sample;
          red_d   = sample_i.red_sample;
          now_d   = sample_i.time_ms;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        beat_d = 1'b0;
        if (ir_q < fthr_q) begin
          // No finger: clear filters, rate, SpO2 average and accumulators.
          finger_d = 1'b0;
          ir_dc_d  = '0;
          red_dc_d = '0;
          ir_ac_d  = '0;
          red_ac_d = '0;
          band_d   = '0;
          env_d    = '0;
          prev_d   = '0;
          rising_d = 1'b0;
          bpm_sm_d = '0;
          ifill_d  = '0;
          spavg_d  = '0;
          sfill_d  = '0;
          ir_sq_d  = '0;
          red_sq_d = '0;
          acnt_d   = '0;
          state_d  = S_FIN;
        end else begin
          finger_d = 1'b1;
          if (ir_dc_q == '0) begin
            // First finger sample seeds both DC levels.
            ir_dc_d  = irx;
            red_dc_d = redx;
            mul_d    = scale_op('0, K_DC);
          end else begin
            mul_d = scale_op(irx - ir_dc_q, K_DC);
          end
          ret_d   = S_DC_IR;
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        state_d = ret_q;
      end

      S_DC_IR: begin
        ir_dc_d = ir_dc_q + sc;
        mul_d   = scale_op(redx - red_dc_q, K_DC);
        ret_d   = S_DC_RED;
        state_d = S_MUL;
      end

      S_DC_RED: begin
        red_dc_d = red_dc_q + sc;
        mul_d    = scale_op(ir_raw - ir_ac_q, K_AC);
        ret_d    = S_AC_IR;
        state_d  = S_MUL;
      end

      S_AC_IR: begin
        ir_ac_d = ir_ac_q + sc;
        mul_d   = scale_op(red_raw - red_ac_q, K_AC);
        ret_d   = S_AC_RED;
        state_d = S_MUL;
      end

      S_AC_RED: begin
        red_ac_d = red_ac_q + sc;
        mul_d    = square_op(ir_ac_q);
        ret_d    = S_SQ_IR;
        state_d  = S_MUL;
      end

      S_SQ_IR: begin
        ir_sq_d = sat_add64(ir_sq_q, prod_q);
        mul_d   = square_op(red_ac_q);
        ret_d   = S_SQ_RED;
        state_d = S_MUL;
      end

      S_SQ_RED: begin
        red_sq_d = sat_add64(red_sq_q, prod_q);
        if (acnt_q != 16'hFFFF) begin
          acnt_d = acnt_q + 1'b1;
        end
        mul_d   = scale_op(ir_raw - band_q, K_BAND);
        ret_d   = S_BAND;
        state_d = S_MUL;
      end

      S_BAND: begin
        band_d  = band_q + sc;
        mul_d   = scale_op(env_q, K_ENV);
        ret_d   = S_ENV;
        state_d = S_MUL;
      end

      S_ENV: begin
        env_d   = env_new;
        mul_d   = scale_op(env_new, K_THR);
        ret_d   = S_THR;
        state_d = S_MUL;
      end

      // Peak test, beat acceptance and interval storage.
      S_THR: begin
        rising_d = rising;
        prev_d   = band_q;
        ivl_d    = now_q - last_beat_q;
        beat_d   = peak && ((now_q - last_beat_q) >= 32'(min_ivl_q));
        state_d  = S_FIN;
        if (peak && ((now_q - last_beat_q) >= 32'(min_ivl_q))) begin
          last_beat_d = now_q;
          if ((now_q - last_beat_q) <= 32'(max_ivl_q)) begin
            iring_d[iwp_q] = ((now_q - last_beat_q) > 32'(IVL_CAP)) ? IVL_CAP
                           : IVL_W'(now_q - last_beat_q);
            iwp_d   = (iwp_q == IPTR_W'(INTERVAL_DEPTH - 1)) ? '0 : iwp_q + 1'b1;
            ifill_d = ifill_nx;
            irp_d   = iwp_q;
            step_d  = '0;
            isum_d  = '0;
            state_d = (ifill_nx >= IFILL_W'(2)) ? S_BPM_SUM : S_SP_START;
          end
        end
      end

      // Sum of the most recent intervals, newest first.
      S_BPM_SUM: begin
        isum_d = isum_q + ISUM_W'(iring_q[irp_q]);
        irp_d  = (irp_q == '0) ? IPTR_W'(INTERVAL_DEPTH - 1) : irp_q - 1'b1;
        step_d = step_q + 1'b1;
        if (STEP_W'(step_q + 1'b1) == STEP_W'(ifill_q)) begin
          mul_d.a   = K_BPM_NUM;
          mul_d.b   = 32'(ifill_q);
          mul_d.neg = 1'b0;
          ret_d     = S_BPM_NUM;
          state_d   = S_MUL;
        end
      end

      S_BPM_NUM: begin
        if (isum_q == '0) begin
          bpm_d   = BPM_CAP;
          state_d = S_BPM_SMOOTH;
        end else begin
          iter_req.start = 1'b1;
          iter_req.op    = ITER_DIV;
          iter_req.num   = prod_q + 64'(isum_q >> 1);
          iter_req.den   = 64'(isum_q);
          state_d        = S_BPM_DIV;
        end
      end

      S_BPM_DIV: begin
        if (iter_rsp.done) begin
          bpm_d   = (iter_rsp.result > 64'(BPM_CAP)) ? BPM_CAP : iter_rsp.result[15:0];
          state_d = S_BPM_SMOOTH;
        end
      end

      S_BPM_SMOOTH: begin
        if (bpm_sm_q == '0) begin
          bpm_sm_d = bpm_q;
          state_d  = S_SP_START;
        end else begin
          mul_d   = scale_op($signed({16'd0, bpm_q}) - $signed({16'd0, bpm_sm_q}), K_SMOOTH);
          ret_d   = S_BPM_APPLY;
          state_d = S_MUL;
        end
      end

      S_BPM_APPLY: begin
        bpm_sm_d = 16'($signed({16'd0, bpm_sm_q}) + sc);
        state_d  = S_SP_START;
      end

      // SpO2: mean squares, roots, ratio of ratios, clamp and average.
      S_SP_START: begin
        if (acnt_q <= MIN_AC_SAMPLES) begin
          state_d = S_FIN;
        end else begin
          iter_req.start = 1'b1;
          iter_req.op    = ITER_DIV;
          iter_req.num   = ir_sq_q;
          iter_req.den   = 64'(acnt_q);
          state_d        = S_SP_D1;
        end
      end

      S_SP_D1: begin
        if (iter_rsp.done) begin
          iter_req.start = 1'b1;
          iter_req.op    = ITER_SQRT;
          iter_req.num   = iter_rsp.result;
          state_d        = S_SP_S1;
        end
      end

      S_SP_S1: begin
        if (iter_rsp.done) begin
          ir_rms_d       = iter_rsp.result[31:0];
          iter_req.start = 1'b1;
          iter_req.op    = ITER_DIV;
          iter_req.num   = red_sq_q;
          iter_req.den   = 64'(acnt_q);
          state_d        = S_SP_D2;
        end
      end

      S_SP_D2: begin
        if (iter_rsp.done) begin
          iter_req.start = 1'b1;
          iter_req.op    = ITER_SQRT;
          iter_req.num   = iter_rsp.result;
          state_d        = S_SP_S2;
        end
      end

      S_SP_S2: begin
        if (iter_rsp.done) begin
          red_rms_d = iter_rsp.result[31:0];
          if ((ir_rms_q <= MIN_RMS_Q4) || (iter_rsp.result[31:0] <= MIN_RMS_Q4) ||
              (ir_dc_q <= DC_MIN_Q) || (red_dc_q <= DC_MIN_Q)) begin
            state_d = S_FIN;
          end else begin
            mul_d.a   = iter_rsp.result[31:0];
            mul_d.b   = 32'(ir_dc_q >>> FRAC_BITS);
            mul_d.neg = 1'b0;
            ret_d     = S_SP_NUM;
            state_d   = S_MUL;
          end
        end
      end

      S_SP_NUM: begin
        num_d     = prod_q << 16;
        mul_d.a   = ir_rms_q;
        mul_d.b   = 32'(red_dc_q >>> FRAC_BITS);
        mul_d.neg = 1'b0;
        ret_d     = S_SP_DEN;
        state_d   = S_MUL;
      end

      S_SP_DEN: begin
        iter_req.start = 1'b1;
        iter_req.op    = ITER_DIV;
        iter_req.num   = num_q;
        iter_req.den   = prod_q;
        state_d        = S_SP_R;
      end

      S_SP_R: begin
        if (iter_rsp.done) begin
          if (iter_rsp.result >= R_LOW_CLAMP) begin
            // Ratio high enough that the estimate sits at the lower clamp.
            sval_d  = SPO2_LOW;
            state_d = S_SP_WRITE;
          end else begin
            mul_d.a   = iter_rsp.result[31:0];
            mul_d.b   = K_SPO2_SLOPE;
            mul_d.neg = 1'b0;
            ret_d     = S_SP_VAL;
            state_d   = S_MUL;
          end
        end
      end

      S_SP_VAL: begin
        sval_d  = (spr > SPO2_HIGH) ? SPO2_W'(SPO2_HIGH) : spr[SPO2_W-1:0];
        state_d = S_SP_WRITE;
      end

      S_SP_WRITE: begin
        sring_d[swp_q] = sval_q;
        swp_d   = (swp_q == SPTR_W'(SPO2_DEPTH - 1)) ? '0 : swp_q + 1'b1;
        sfill_d = sfill_nx;
        srp_d   = swp_q;
        step_d  = '0;
        ssum_d  = '0;
        state_d = S_SP_SUM;
      end

      S_SP_SUM: begin
        ssum_d = ssum_nx;
        srp_d  = (srp_q == '0) ? SPTR_W'(SPO2_DEPTH - 1) : srp_q - 1'b1;
        step_d = step_q + 1'b1;
        if (STEP_W'(step_q + 1'b1) == STEP_W'(sfill_q)) begin
          iter_req.start = 1'b1;
          iter_req.op    = ITER_DIV;
          iter_req.num   = 64'(ssum_nx) + 64'(sfill_q >> 1);
          iter_req.den   = 64'(sfill_q);
          state_d        = S_SP_AVG;
        end
      end

      S_SP_AVG: begin
        if (iter_rsp.done) begin
          spavg_d = iter_rsp.result[SPO2_W-1:0];
          state_d = S_FIN;
        end
      end

      // Accumulator clear, beat timeout and hand-off to the output register.
      S_FIN: begin
        if (finger_q && beat_q) begin
          ir_sq_d  = '0;
          red_sq_d = '0;
          acnt_d   = '0;
        end
        if (tmo_hit) begin
          bpm_sm_d    = '0;
          ifill_d     = '0;
          last_beat_d = now_q;
          ir_sq_d     = '0;
          red_sq_d    = '0;
          acnt_d      = '0;
        end
        if (!ov_q || result_o.ready) begin
          ov_d     = 1'b1;
          o_fing_d = finger_q;
          o_beat_d = finger_q && beat_q;
          o_bpm_d  = (bpm_int > BPM_OUT_CAP) ? BPM_W'(BPM_OUT_CAP) : bpm_int[BPM_W-1:0];
          o_spo2_d = spavg_q;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Product register after the shared multiplier.
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_q.a) * 64'(mul_q.b);
  end

  // Configuration, estimator state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fthr_q      <= FINGER_THR_RST;
      min_ivl_q   <= MIN_IVL_RST;
      max_ivl_q   <= MAX_IVL_RST;
      tmo_q       <= TIMEOUT_RST;
      pfloor_q    <= FLOOR_RST;
      ir_q        <= '0;
      red_q       <= '0;
      now_q       <= '0;
      mul_q       <= '0;
      ir_dc_q     <= '0;
      red_dc_q    <= '0;
      ir_ac_q     <= '0;
      red_ac_q    <= '0;
      band_q      <= '0;
      env_q       <= '0;
      prev_q      <= '0;
      rising_q    <= 1'b0;
      last_beat_q <= '0;
      iring_q     <= '{default: '0};
      iwp_q       <= '0;
      irp_q       <= '0;
      ifill_q     <= '0;
      isum_q      <= '0;
      bpm_q       <= '0;
      bpm_sm_q    <= '0;
      ir_sq_q     <= '0;
      red_sq_q    <= '0;
      acnt_q      <= '0;
      sring_q     <= '{default: '0};
      swp_q       <= '0;
      srp_q       <= '0;
      sfill_q     <= '0;
      ssum_q      <= '0;
      spavg_q     <= '0;
      sval_q      <= '0;
      ir_rms_q    <= '0;
      red_rms_q   <= '0;
      num_q       <= '0;
      finger_q    <= 1'b0;
      beat_q      <= 1'b0;
      ivl_q       <= '0;
      step_q      <= '0;
      ov_q        <= 1'b0;
      o_fing_q    <= 1'b0;
      o_beat_q    <= 1'b0;
      o_bpm_q     <= '0;
      o_spo2_q    <= '0;
    end else begin
      fthr_q      <= fthr_d;
      min_ivl_q   <= min_ivl_d;
      max_ivl_q   <= max_ivl_d;
      tmo_q       <= tmo_d;
      pfloor_q    <= pfloor_d;
      ir_q        <= ir_d;
      red_q       <= red_d;
      now_q       <= now_d;
      mul_q       <= mul_d;
      ir_dc_q     <= ir_dc_d;
      red_dc_q    <= red_dc_d;
      ir_ac_q     <= ir_ac_d;
      red_ac_q    <= red_ac_d;
      band_q      <= band_d;
      env_q       <= env_d;
      prev_q      <= prev_d;
      rising_q    <= rising_d;
      last_beat_q <= last_beat_d;
      iring_q     <= iring_d;
      iwp_q       <= iwp_d;
      irp_q       <= irp_d;
      ifill_q     <= ifill_d;
      isum_q      <= isum_d;
      bpm_q       <= bpm_d;
      bpm_sm_q    <= bpm_sm_d;
      ir_sq_q     <= ir_sq_d;
      red_sq_q    <= red_sq_d;
      acnt_q      <= acnt_d;
      sring_q     <= sring_d;
      swp_q       <= swp_d;
      srp_q       <= srp_d;
      sfill_q     <= sfill_d;
      ssum_q      <= ssum_d;
      spavg_q     <= spavg_d;
      sval_q      <= sval_d;
      ir_rms_q    <= ir_rms_d;
      red_rms_q   <= red_rms_d;
      num_q       <= num_d;
      finger_q    <= finger_d;
      beat_q      <= beat_d;
      ivl_q       <= ivl_d;
      step_q      <= step_d;
      ov_q        <= ov_d;
      o_fing_q    <= o_fing_d;
      o_beat_q    <= o_beat_d;
      o_bpm_q     <= o_bpm_d;
      o_spo2_q    <= o_spo2_d;
    end
  end

endmodule

>>> rtl/ppgs_iter_unit.sv
// Shared multi-cycle unit: restoring divider and bitwise integer square root.
`timescale 1ns / 1ps

module ppgs_iter_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppgs_pkg::ppgs_iter_req_t req_i,
  output ppgs_pkg::ppgs_iter_rsp_t rsp_o
);
  import ppgs_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  ppgs_iter_op_e     op_q, op_d;
  logic [ICNT_W-1:0] cnt_q, cnt_d;
  logic [64:0]       acc_q, acc_d;   // remainder or radicand
  logic [63:0]       quo_q, quo_d;   // quotient or root
  logic [63:0]       aux_q, aux_d;   // divisor or root bit
  logic [64:0]       lhs, rhs, diff;
  logic              ge;

  // One step of the selected operation per cycle while busy.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    quo_d  = quo_q;
    aux_d  = aux_q;

    if (op_q == ITER_DIV) begin
      lhs = {acc_q[63:0], quo_q[63]};
      rhs = {1'b0, aux_q};
    end else begin
      lhs = acc_q;
      rhs = {1'b0, quo_q + aux_q};
    end
    ge   = lhs >= rhs;
    diff = lhs - rhs;

    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      if (req_i.op == ITER_DIV) begin
        acc_d = '0;
        quo_d = req_i.num;
        aux_d = req_i.den;
        cnt_d = ICNT_W'(DIV_STEPS - 1);
      end else begin
        acc_d = {1'b0, req_i.num};
        quo_d = '0;
        aux_d = 64'd1 << 62;
        cnt_d = ICNT_W'(SQRT_STEPS - 1);
      end
    end else if (busy_q) begin
      if (op_q == ITER_DIV) begin
        acc_d = ge ? diff : lhs;
        quo_d = {quo_q[62:0], ge};
      end else begin
        if (ge) begin
          acc_d = diff;
          quo_d = (quo_q >> 1) + aux_q;
        end else begin
          quo_d = quo_q >> 1;
        end
        aux_d = aux_q >> 2;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ITER_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    aux_q <= aux_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = quo_q;

endmodule

>>> tb/ppg_heart_rate_spo2_top_test.sv
// Self-checking testbench of the PPG heart rate and SpO2 estimator top level.
`timescale 1ns / 1ps

module ppg_heart_rate_spo2_top_test;
  import ppgs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES = 500;

  typedef struct {
    logic              finger;
    logic              beat;
    logic [BPM_W-1:0]  bpm;
    logic [SPO2_W-1:0] spo2;
  } vitals_t;

  logic clk_i;
  logic rst_ni;

  ppgs_in_if  sample_if ();
  ppgs_out_if result_if ();
  ppgs_cfg_if cfg_if ();

  ppg_heart_rate_spo2_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if.sink),
    .result_o(result_if.source),
    .cfg_i   (cfg_if.sink)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers.
  logic [17:0] finger_thr_q;
  logic [15:0] min_ivl_q, max_ivl_q, timeout_q, floor_q;

  // Predictor copy of the estimator state.
  longint            ir_dc, red_dc, ir_ac, red_ac, band_ir, envelope, prev_band;
  bit                rising_q;
  logic [31:0]       last_beat_ms;
  longint unsigned   ivl_hist[INTERVAL_DEPTH];
  int unsigned       ivl_wr, ivl_fill;
  int unsigned       bpm_q4;
  longint unsigned   ir_sq_acc, red_sq_acc;
  int unsigned       ac_count;
  longint unsigned   spo2_hist[SPO2_DEPTH];
  int unsigned       spo2_wr, spo2_fill, spo2_avg;

  vitals_t     expected_reports[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  logic [31:0] clock_ms;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned ready_pct;
  int unsigned hold_seq;

  // Rounded Q16 scaling, half away from zero.
  function automatic longint scale_q16(longint v, longint unsigned k);
    longint unsigned m;
    longint unsigned r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = (m * k + 64'd32768) >> 16;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
  endfunction

  function automatic longint unsigned ac_square(longint ac);
    longint unsigned m;
    m = (ac < 0) ? longint'(-ac) : longint'(ac);
    m = m >> (FRAC_BITS - 4);
    return m * m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void clear_accumulators();
    ir_sq_acc = 0;
    red_sq_acc = 0;
    ac_count = 0;
  endfunction

  function automatic void clear_finger_state();
    ir_dc = 0; red_dc = 0; ir_ac = 0; red_ac = 0;
    band_ir = 0; envelope = 0; prev_band = 0;
    rising_q = 0;
    bpm_q4 = 0; ivl_fill = 0;
    spo2_avg = 0; spo2_fill = 0;
    clear_accumulators();
  endfunction

  function automatic void reset_estimate();
    finger_thr_q = FINGER_THR_RST;
    min_ivl_q = MIN_IVL_RST;
    max_ivl_q = MAX_IVL_RST;
    timeout_q = TIMEOUT_RST;
    floor_q = FLOOR_RST;
    clear_finger_state();
    last_beat_ms = 0;
    foreach (ivl_hist[i]) ivl_hist[i] = 0;
    foreach (spo2_hist[i]) spo2_hist[i] = 0;
    ivl_wr = 0;
    spo2_wr = 0;
  endfunction

  // Rate average over the most recent stored intervals, then 0.7/0.3 smoothing.
  function automatic void update_rate();
    longint unsigned sum;
    longint unsigned bpm;
    sum = 0;
    for (int unsigned k = 0; k < ivl_fill; k++)
      sum += ivl_hist[(ivl_wr + INTERVAL_DEPTH - 1 - k) % INTERVAL_DEPTH];
    if (sum == 0) begin
      bpm = 64'd2047 * 16;
    end else begin
      bpm = (64'd600000 * ivl_fill * 16 + sum / 2) / sum;
      if (bpm > 64'd2047 * 16) bpm = 64'd2047 * 16;
    end
    if (bpm_q4 == 0) bpm_q4 = int'(bpm);
    else bpm_q4 = int'(longint'(bpm_q4) + scale_q16(longint'(bpm) - longint'(bpm_q4), 19661));
  endfunction

  // Ratio of ratios from the AC RMS and DC levels, clamped and averaged.
  function automatic void update_saturation();
    longint unsigned ir_rms, red_rms, num, den, r, sum;
    longint v;
    int unsigned val;
    if (ac_count <= 10) return;
    ir_rms = int_sqrt(ir_sq_acc / ac_count);
    red_rms = int_sqrt(red_sq_acc / ac_count);
    if (ir_rms <= 160 || red_rms <= 160) return;
    if (ir_dc <= (longint'(10000) <<< FRAC_BITS) ||
        red_dc <= (longint'(10000) <<< FRAC_BITS)) return;
    num = (red_rms * longint'(ir_dc >>> FRAC_BITS)) << 16;
    den = ir_rms * longint'(red_dc >>> FRAC_BITS);
    r = num / den;
    v = longint'(1040) * 65536 - longint'(170) * longint'(r);
    if (v <= longint'(850) * 65536) begin
      val = 850;
    end else begin
      val = int'((longint'(v) + 32768) >>> 16);
      if (val > 1000) val = 1000;
    end
    spo2_hist[spo2_wr % SPO2_DEPTH] = val;
    spo2_wr = (spo2_wr + 1) % SPO2_DEPTH;
    if (spo2_fill < SPO2_DEPTH) spo2_fill++;
    sum = 0;
    for (int unsigned k = 0; k < spo2_fill; k++)
      sum += spo2_hist[(spo2_wr + SPO2_DEPTH - 1 - k) % SPO2_DEPTH];
    spo2_avg = int'((sum + spo2_fill / 2) / spo2_fill);
  endfunction

  // Works out the report for one accepted sample and advances the state.
  function automatic vitals_t estimate_vitals(logic [17:0] ir, logic [17:0] red,
                                              logic [31:0] now);
    vitals_t rep;
    longint irx, redx, ir_raw, red_raw, mag, thr, floor_val;
    logic [31:0] interval;
    bit rising, peak, beat;
    int unsigned bpm_out;
    if (ir < finger_thr_q) begin
      clear_finger_state();
      rep.finger = 0; rep.beat = 0; rep.bpm = 0; rep.spo2 = 0;
      return rep;
    end
    irx = longint'(ir) <<< FRAC_BITS;
    redx = longint'(red) <<< FRAC_BITS;
    if (ir_dc == 0) begin
      ir_dc = irx;
      red_dc = redx;
    end
    ir_dc += scale_q16(irx - ir_dc, 328);
    red_dc += scale_q16(redx - red_dc, 328);
    ir_raw = irx - ir_dc;
    red_raw = redx - red_dc;
    ir_ac += scale_q16(ir_raw - ir_ac, 6554);
    red_ac += scale_q16(red_raw - red_ac, 6554);
    ir_sq_acc = add_sat(ir_sq_acc, ac_square(ir_ac));
    red_sq_acc = add_sat(red_sq_acc, ac_square(red_ac));
    if (ac_count < 65535) ac_count++;

    band_ir += scale_q16(ir_raw - band_ir, 16384);
    envelope = scale_q16(envelope, 64553);
    mag = (band_ir < 0) ? -band_ir : band_ir;
    if (mag > envelope) envelope = mag;
    thr = scale_q16(envelope, 19661);
    floor_val = longint'(floor_q) <<< FRAC_BITS;
    if (thr < floor_val) thr = floor_val;

    rising = band_ir > prev_band;
    peak = rising_q && !rising && band_ir > thr;
    rising_q = rising;
    prev_band = band_ir;

    interval = now - last_beat_ms;
    beat = peak && (interval >= min_ivl_q);
    if (beat) begin
      last_beat_ms = now;
      if (interval <= max_ivl_q) begin
        ivl_hist[ivl_wr % INTERVAL_DEPTH] = (interval > 2047) ? 2047 : interval;
        ivl_wr = (ivl_wr + 1) % INTERVAL_DEPTH;
        if (ivl_fill < INTERVAL_DEPTH) ivl_fill++;
        if (ivl_fill >= 2) update_rate();
        update_saturation();
      end
      clear_accumulators();
    end
    if (interval > timeout_q) begin
      bpm_q4 = 0;
      ivl_fill = 0;
      last_beat_ms = now;
      clear_accumulators();
    end

    bpm_out = (bpm_q4 + 8) >> 4;
    if (bpm_out > 2047) bpm_out = 2047;
    rep.finger = 1;
    rep.beat = beat;
    rep.bpm = bpm_out[BPM_W-1:0];
    rep.spo2 = spo2_avg[SPO2_W-1:0];
    return rep;
  endfunction

  // Prediction on every accepted sample and register write.
  always @(posedge clk_i) begin
    if (rst_ni && sample_if.valid && sample_if.ready)
      expected_reports.push_back(estimate_vitals(sample_if.ir_sample, sample_if.red_sample,
                                                 sample_if.time_ms));
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_FINGER_THR: finger_thr_q = cfg_if.data[17:0];
        CFG_MIN_IVL:    min_ivl_q = cfg_if.data[15:0];
        CFG_MAX_IVL:    max_ivl_q = cfg_if.data[15:0];
        CFG_TIMEOUT:    timeout_q = cfg_if.data[15:0];
        CFG_PEAK_FLOOR: floor_q = cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  // Result checking against the oldest expected report.
  always @(posedge clk_i) begin
    vitals_t exp_rep;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result beat");
        fail_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (result_if.finger_present !== exp_rep.finger) begin
          $error("finger_present: expected %0d, actual %0d", exp_rep.finger,
                 result_if.finger_present);
          fail_count++;
        end
        if (result_if.beat_detected !== exp_rep.beat) begin
          $error("beat_detected: expected %0d, actual %0d", exp_rep.beat,
                 result_if.beat_detected);
          fail_count++;
        end
        if (result_if.bpm_tenths !== exp_rep.bpm) begin
          $error("bpm_tenths: expected %0d, actual %0d", exp_rep.bpm, result_if.bpm_tenths);
          fail_count++;
        end
        if (result_if.spo2_tenths !== exp_rep.spo2) begin
          $error("spo2_tenths: expected %0d, actual %0d", exp_rep.spo2,
                 result_if.spo2_tenths);
          fail_count++;
        end
      end
    end
  end

  // Receiver stalls on its own pattern, with long hold-offs on request.
  always @(posedge clk_i) begin
    int unsigned hold_left;
    int unsigned seen_seq;
    int unsigned phase_cnt;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      hold_left = 0;
      seen_seq = 0;
      phase_cnt = 0;
    end else begin
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_left = HOLD_OFF_CYCLES;
      end
      phase_cnt++;
      if (phase_cnt % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: ready_pct = 100;
          1: ready_pct = 70;
          default: ready_pct = 25;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ppg_heart_rate_spo2_top regression: fail");
        $finish;
      end
    end
  end

  // Sends one sample; returns at the step of its acceptance with valid still high.
  task automatic send_sample(logic [17:0] ir, logic [17:0] red, logic [31:0] now);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        sample_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_if.valid <= 1'b1;
    sample_if.ir_sample <= ir;
    sample_if.red_sample <= red;
    sample_if.time_ms <= now;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  // Lowers valid and waits until every report has come back.
  task automatic drain();
    sample_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; valid drops for a cycle after the write is taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [17:0] thr, logic [15:0] min_ivl, logic [15:0] max_ivl,
                          logic [15:0] timeout, logic [15:0] floor_val);
    drain();
    write_reg(CFG_FINGER_THR, thr);
    write_reg(CFG_MIN_IVL, {2'b00, min_ivl});
    write_reg(CFG_MAX_IVL, {2'b00, max_ivl});
    write_reg(CFG_TIMEOUT, {2'b00, timeout});
    write_reg(CFG_PEAK_FLOOR, {2'b00, floor_val});
  endtask

  // Pulse train with a fast rise and slow fall on both channels.
  task automatic send_pulses(int unsigned n, int unsigned ir_base, int unsigned ir_amp,
                             int unsigned red_base, int unsigned red_amp,
                             int unsigned period, int unsigned dt, int unsigned noise);
    int unsigned ph, rise, shape;
    for (int unsigned i = 0; i < n; i++) begin
      clock_ms += dt;
      ph = clock_ms % period;
      rise = period / 4;
      shape = (ph < rise) ? ph * 1024 / rise : 1024 - (ph - rise) * 1024 / (period - rise);
      send_sample(18'(ir_base + ir_amp * shape / 1024 + $urandom_range(0, noise)),
                  18'(red_base + red_amp * shape / 1024 + $urandom_range(0, noise)),
                  clock_ms);
    end
  endtask

  // Unstructured samples over the whole field ranges.
  task automatic send_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      clock_ms = ($urandom_range(0, 3) == 0) ? $urandom() : clock_ms + $urandom_range(0, 400);
      send_sample(18'($urandom()), 18'($urandom()), clock_ms);
    end
  endtask

  // Field extremes, finger edges, wrap of the timestamp and beat timeout.
  task automatic test_directed();
    send_sample(18'd0, 18'd0, 32'd0);
    send_sample(18'd49999, 18'h3FFFF, 32'd10);
    send_sample(18'd50000, 18'h3FFFF, 32'd20);
    send_sample(18'h3FFFF, 18'd0, 32'd30);
    send_sample(18'd60000, 18'd40000, 32'd40);
    send_sample(18'd0, 18'd0, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_F000;
    send_pulses(12, 100000, 3000, 80000, 2000, 800, 10, 20);
    send_sample(18'd100000, 18'd80000, clock_ms + 32'd5000);
    clock_ms += 5000;
    send_sample(18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
    send_sample(18'h3FFFF, 18'h3FFFF, 32'h0000_0000);
  endtask

  task automatic test_heartbeat_default();
    send_pulses(350, 100000, 4000, 80000, 2500, 800, 10, 50);
    send_pulses(150, 150000, 2000, 120000, 3000, 600, 10, 30);
  endtask

  task automatic test_open_limits();
    set_regs(18'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_pulses(150, 90000, 3000, 70000, 2000, 900, 10, 40);
    send_noise(40);
  endtask

  task automatic test_tight_limits();
    set_regs(18'h3FFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_noise(40);
    send_pulses(20, 200000, 62143, 100000, 5000, 700, 10, 10);
  endtask

  task automatic test_mixed_settings();
    set_regs(18'd20000, 16'd250, 16'd1500, 16'd2500, 16'd50);
    write_reg(CFG_UNUSED_IDX, 18'h3FFFF);
    for (int unsigned g = 0; g < 16; g++) begin
      send_pulses($urandom_range(20, 40), $urandom_range(30000, 200000),
                  $urandom_range(500, 8000), $urandom_range(15000, 150000),
                  $urandom_range(300, 6000), $urandom_range(400, 1500),
                  $urandom_range(8, 20), $urandom_range(0, 80));
      case ($urandom_range(0, 3))
        0: send_sample(18'($urandom_range(0, 19999)), 18'($urandom()), clock_ms + 10);
        1: clock_ms += $urandom_range(2000, 6000);
        2: send_noise(2);
        default: ;
      endcase
    end
  endtask

  // Receiver holds off while samples keep coming, so the block backs up.
  task automatic test_backpressure();
    set_regs(18'd50000, 16'd300, 16'd2000, 16'd3000, 16'd100);
    gap_max = 0;
    hold_seq++;
    send_pulses(150, 100000, 4000, 80000, 2500, 750, 10, 50);
    gap_max = 6;
  endtask

  initial begin
    rst_ni = 1'b0;
    sample_if.valid = 1'b0;
    sample_if.ir_sample = '0;
    sample_if.red_sample = '0;
    sample_if.time_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FINGER_THR;
    cfg_if.data = '0;
    fail_count = 0;
    idle_cycles = 0;
    clock_ms = 0;
    burst_left = 0;
    gap_max = 6;
    ready_pct = 100;
    hold_seq = 0;
    reset_estimate();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_heartbeat_default();
    test_open_limits();
    test_tight_limits();
    test_mixed_settings();
    test_backpressure();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("ppg_heart_rate_spo2_top regression: pass");
    end else begin
      $display("ppg_heart_rate_spo2_top regression: fail");
    end
    $finish;
  end

endmodule
